/* src/psms_pkg.sv */
// shared types and codes for the packed special matrix store
package psms_pkg;

    // element and index widths
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int SIZE_W  = 5;
    localparam int MODE_W  = 3;
    localparam int CFG_W   = 5;
    localparam int MAP_W   = 12;

    // matrix shape codes
    localparam logic [MODE_W-1:0] MODE_DIAG  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOWER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPPER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SYMM  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRI   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    // address map result
    typedef struct packed {
        logic             stored;
        logic [1:0]       status;
        logic [MAP_W-1:0] addr;
    } t_map;

endpackage

/* src/psms_ram.sv */
// generic single port ram with registered read
module psms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 136
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/psms_map.sv */
// maps a (row, col) pair to its packed address and status
module psms_map #(
    parameter int MAX_ORDER   = 16,
    parameter int STORE_DEPTH = 136
) (
    input  logic [psms_pkg::MODE_W-1:0] i_mode,
    input  logic [psms_pkg::SIZE_W-1:0] i_size,
    input  logic                        i_op,
    input  logic [psms_pkg::IDX_W-1:0]  i_row,
    input  logic [psms_pkg::IDX_W-1:0]  i_col,
    output psms_pkg::t_map              o_map
);

    localparam int MW = psms_pkg::MAP_W;

    logic [psms_pkg::SIZE_W-1:0] n_eff;
    logic [MW-1:0]               rw;
    logic [MW-1:0]               cw;
    logic [MW-1:0]               nw;
    logic [MW-1:0]               hi;
    logic [MW-1:0]               lo;
    logic [MW-1:0]               addr;
    logic                        mapped;
    logic                        in_range;

    // sizes above the supported order fall back to it
    assign n_eff = (32'(i_size) > MAX_ORDER) ? psms_pkg::SIZE_W'(MAX_ORDER) : i_size;

    assign rw = MW'(i_row);
    assign cw = MW'(i_col);
    assign nw = MW'(n_eff);
    assign hi = (cw > rw) ? cw : rw;
    assign lo = (cw > rw) ? rw : cw;

    assign in_range = (MW'(i_row) < nw) && (MW'(i_col) < nw);

    always_comb begin
        mapped = 1'b0;
        addr   = '0;
        case (i_mode)
            psms_pkg::MODE_DIAG: begin
                mapped = (rw == cw);
                addr   = rw;
            end
            psms_pkg::MODE_LOWER: begin
                mapped = (cw <= rw);
                addr   = ((rw * (rw + MW'(1))) >> 1) + cw;
            end
            psms_pkg::MODE_UPPER: begin
                // row zero makes the triangle term vanish
                mapped = (cw >= rw);
                addr   = rw * nw - ((rw * (rw - MW'(1))) >> 1) + cw - rw;
            end
            psms_pkg::MODE_SYMM: begin
                mapped = 1'b1;
                addr   = ((hi * (hi + MW'(1))) >> 1) + lo;
            end
            psms_pkg::MODE_TRI: begin
                if (rw == cw + MW'(1)) begin
                    mapped = 1'b1;
                    addr   = rw - MW'(1);
                end else if (rw == cw) begin
                    mapped = 1'b1;
                    addr   = nw - MW'(1) + rw;
                end else if (cw == rw + MW'(1)) begin
                    mapped = 1'b1;
                    addr   = (nw << 1) - MW'(1) + rw;
                end
            end
            default: begin
                mapped = 1'b0;
                addr   = '0;
            end
        endcase
    end

    always_comb begin
        o_map.addr   = addr;
        o_map.stored = 1'b0;
        if (!in_range) begin
            o_map.status = psms_pkg::ST_RANGE;
        end else if (!mapped) begin
            o_map.status = (i_op == psms_pkg::OP_WRITE) ? psms_pkg::ST_ZERO : psms_pkg::ST_OK;
        end else if (addr >= MW'(STORE_DEPTH)) begin
            o_map.status = psms_pkg::ST_RANGE;
        end else begin
            o_map.status = psms_pkg::ST_OK;
            o_map.stored = 1'b1;
        end
    end

endmodule

/* src/packed_special_matrix_store.sv */
// top level: packed special matrix store with address map, ram and output register
// a transfer passes through the ram stage, then the output register, before its result shows
// throughput: one item per cycle unless stalled, set by the single ram port (one access per item)
// o_stall rises only while the ram stage and the output register both hold items and i_stall is high
// reset (i_rst_n low, synchronous): pipeline emptied, mode diagonal, size 16
// the ram is not cleared; an entry reads as undefined until it is written
module packed_special_matrix_store #(
    parameter int MAX_ORDER   = 16,
    parameter int STORE_DEPTH = 136
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [psms_pkg::CFG_W-1:0]  i_cfg_data,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [psms_pkg::IDX_W-1:0]  i_row,
    input  logic [psms_pkg::IDX_W-1:0]  i_col,
    input  logic signed [psms_pkg::DATA_W-1:0] i_write_value,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [psms_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                  o_status
);

    localparam int AW = $clog2(STORE_DEPTH);

    // configuration registers
    logic [psms_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [psms_pkg::SIZE_W-1:0] r_size, n_size;

    // ram stage: item whose ram read is in flight
    logic       r_s1_valid, n_s1_valid;
    logic       r_s1_read,  n_s1_read;
    logic [1:0] r_s1_status, n_s1_status;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [psms_pkg::DATA_W-1:0]  r_out_value, n_out_value;
    logic [1:0]                   r_out_status, n_out_status;

    psms_pkg::t_map              map;
    logic                        adv_out;
    logic                        adv_s1;
    logic                        accept;
    logic                        ram_we;
    logic                        ram_re;
    logic [psms_pkg::DATA_W-1:0] ram_rdata;

    psms_map #(
        .MAX_ORDER   (MAX_ORDER),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_map (
        .i_mode (r_mode),
        .i_size (r_size),
        .i_op   (i_op),
        .i_row  (i_row),
        .i_col  (i_col),
        .o_map  (map)
    );

    // output register frees up when empty or when its transfer completes
    assign adv_out = !r_out_valid || !i_stall;
    // ram stage moves on whenever the output register can take its item
    assign adv_s1  = !r_s1_valid || adv_out;
    assign accept  = i_valid && adv_s1;
    assign o_stall = !adv_s1;

    // ram is touched only for stored elements; a held read keeps its data
    assign ram_we = accept && map.stored && (i_op == psms_pkg::OP_WRITE);
    assign ram_re = accept && map.stored && (i_op == psms_pkg::OP_READ);

    psms_ram #(
        .WIDTH (psms_pkg::DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (map.addr[AW-1:0]),
        .i_wdata (i_write_value),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_mode = r_mode;
        n_size = r_size;
        if (i_cfg_we) begin
            case (i_cfg_index)
                psms_pkg::CFG_MODE: n_mode = i_cfg_data[psms_pkg::MODE_W-1:0];
                psms_pkg::CFG_SIZE: n_size = i_cfg_data[psms_pkg::SIZE_W-1:0];
                default:            n_mode = r_mode;
            endcase
        end
    end

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_read   = r_s1_read;
        n_s1_status = r_s1_status;
        if (adv_s1) begin
            n_s1_valid  = i_valid;
            n_s1_read   = map.stored && (i_op == psms_pkg::OP_READ);
            n_s1_status = map.status;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (adv_out) begin
            n_out_valid  = r_s1_valid;
            // writes, errors and structural zeros read as zero
            n_out_value  = r_s1_read ? ram_rdata : '0;
            n_out_status = r_s1_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= psms_pkg::MODE_DIAG;
            r_size      <= psms_pkg::SIZE_W'(16);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_size      <= n_size;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1_read    <= n_s1_read;
        r_s1_status  <= n_s1_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

/* src/psms_checker.sv */
// port level checks for the packed special matrix store, bound to the top level
module psms_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic                        i_cfg_index,
    input logic [psms_pkg::CFG_W-1:0]  i_cfg_data,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_op,
    input logic [psms_pkg::IDX_W-1:0]  i_row,
    input logic [psms_pkg::IDX_W-1:0]  i_col,
    input logic [psms_pkg::DATA_W-1:0] i_write_value,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [psms_pkg::DATA_W-1:0] o_read_value,
    input logic [1:0]                  o_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_status))
        else $error("stalled result changed");

    // status code is one of the three defined ones
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == psms_pkg::ST_OK || o_status == psms_pkg::ST_RANGE ||
                     o_status == psms_pkg::ST_ZERO))
        else $error("undefined status code");

    // errors always carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != psms_pkg::ST_OK |-> o_read_value == '0)
        else $error("error result with nonzero value");

    // back pressure only comes from a stalled result side
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("request stalled while result side is free");

endmodule

bind packed_special_matrix_store psms_checker u_psms_checker (.*);

/* verif/tb_packed_special_matrix_store.sv */
// self-checking testbench for the packed special matrix store: directed corners, random traffic
module tb_packed_special_matrix_store;
    timeunit 1ns;
    timeprecision 1ps;

    // sizes of the block as built
    localparam int ORDER_CAP   = 16;
    localparam int STORE_WORDS = 136;

    // mode codes the block leaves unused (every element a structural zero)
    localparam logic [psms_pkg::MODE_W-1:0] MODE_RSVD_5 = 3'd5;
    localparam logic [psms_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    // idling and run control
    localparam int MAX_WAIT      = 17;
    localparam int SETTLE_CYCLES = 4;       // result passes the ram stage and output register
    localparam int CYCLE_LIMIT   = 600000;  // ~1900 items with the longest idling, many times over
    localparam int REPORT_CAP    = 40;      // keep a broken run's log short
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 120;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic                           i_cfg_we    = 1'b0;
    logic                           i_cfg_index = psms_pkg::CFG_MODE;
    logic [psms_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    // request channel
    logic                               i_valid       = 1'b0;
    logic                               o_stall;
    logic                               i_op          = psms_pkg::OP_WRITE;
    logic [psms_pkg::IDX_W-1:0]         i_row         = '0;
    logic [psms_pkg::IDX_W-1:0]         i_col         = '0;
    logic signed [psms_pkg::DATA_W-1:0] i_write_value = '0;

    // result channel
    logic                               o_valid;
    logic                               i_stall       = 1'b0;
    logic signed [psms_pkg::DATA_W-1:0] o_read_value;
    logic [1:0]                         o_status;

    packed_special_matrix_store u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // one expected result per accepted transfer
    typedef struct {
        logic signed [psms_pkg::DATA_W-1:0] value;
        logic [1:0]                         status;
    } t_elem_result;

    // where an element lives in packed storage
    typedef struct {
        bit in_range;
        bit stored;
        int addr;
    } t_elem_loc;

    t_elem_result expected_results[$];

    // shadow copy of the matrix and of the registers
    logic signed [psms_pkg::DATA_W-1:0] shadow_store [STORE_WORDS];
    bit                                 shadow_written [STORE_WORDS];
    logic [psms_pkg::MODE_W-1:0]        shadow_mode = psms_pkg::MODE_DIAG;
    logic [psms_pkg::SIZE_W-1:0]        shadow_size = 5'd16;

    // idling limits, changed per test
    int tx_max_gap  = MAX_WAIT;
    int rx_max_hold = MAX_WAIT;
    int rx_hold_left = 0;

    // bookkeeping
    int error_count    = 0;
    int cycle_count    = 0;
    int write_count    = 0;
    int read_count     = 0;
    int result_count   = 0;
    int settings_count = 0;

    // order actually in use: sizes above the cap act as the cap
    function automatic int active_order();
        return (shadow_size > ORDER_CAP) ? ORDER_CAP : int'(shadow_size);
    endfunction

    // packing of the current shape: row-major, but diagonal by diagonal for tridiagonal
    function automatic t_elem_loc locate_element(int r, int c);
        t_elem_loc loc;
        int n;
        int t;
        n = active_order();
        loc.in_range = (r < n) && (c < n);
        loc.stored   = 1'b0;
        loc.addr     = 0;
        if (!loc.in_range)
            return loc;
        case (shadow_mode)
            psms_pkg::MODE_DIAG: begin
                if (r == c) begin
                    loc.stored = 1'b1;
                    loc.addr   = r;
                end
            end
            psms_pkg::MODE_LOWER: begin
                if (c <= r) begin
                    loc.stored = 1'b1;
                    loc.addr   = r * (r + 1) / 2 + c;
                end
            end
            psms_pkg::MODE_UPPER: begin
                if (c >= r) begin
                    loc.stored = 1'b1;
                    loc.addr   = r * n - (r * (r - 1)) / 2 + (c - r);
                end
            end
            psms_pkg::MODE_SYMM: begin
                // upper half folds onto the kept lower half
                if (c > r) begin
                    t = r;
                    r = c;
                    c = t;
                end
                loc.stored = 1'b1;
                loc.addr   = r * (r + 1) / 2 + c;
            end
            psms_pkg::MODE_TRI: begin
                if (r == c + 1) begin
                    loc.stored = 1'b1;
                    loc.addr   = r - 1;
                end else if (r == c) begin
                    loc.stored = 1'b1;
                    loc.addr   = n - 1 + r;
                end else if (c == r + 1) begin
                    loc.stored = 1'b1;
                    loc.addr   = 2 * n - 1 + r;
                end
            end
            default: ;
        endcase
        // an address past the end of storage counts as out of range
        if (loc.stored && loc.addr >= STORE_WORDS)
            loc.in_range = 1'b0;
        return loc;
    endfunction

    // apply one accepted transfer to the shadow matrix and queue its result
    function automatic void predict_access(logic op, logic [psms_pkg::IDX_W-1:0] row,
                                           logic [psms_pkg::IDX_W-1:0] col,
                                           logic signed [psms_pkg::DATA_W-1:0] wv);
        t_elem_loc    loc;
        t_elem_result res;
        loc = locate_element(int'(row), int'(col));
        res.value  = '0;
        res.status = psms_pkg::ST_OK;
        if (!loc.in_range) begin
            res.status = psms_pkg::ST_RANGE;
        end else if (!loc.stored) begin
            res.status = (op == psms_pkg::OP_WRITE) ? psms_pkg::ST_ZERO : psms_pkg::ST_OK;
        end else if (op == psms_pkg::OP_WRITE) begin
            shadow_store[loc.addr]   = wv;
            shadow_written[loc.addr] = 1'b1;
        end else begin
            res.value = shadow_store[loc.addr];
        end
        if (op == psms_pkg::OP_WRITE)
            write_count++;
        else
            read_count++;
        expected_results.push_back(res);
    endfunction

    // one request transfer: random gap, hold until accepted, then predict
    task automatic send_access(logic op, logic [psms_pkg::IDX_W-1:0] row,
                               logic [psms_pkg::IDX_W-1:0] col,
                               logic signed [psms_pkg::DATA_W-1:0] wv);
        int gap;
        bit stalled;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_row         <= row;
        i_col         <= col;
        i_write_value <= wv;
        // stall is settled by the falling edge; the transfer happens at the next rise
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        predict_access(op, row, col, wv);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers while the block is idle
    task automatic set_config(logic [psms_pkg::MODE_W-1:0] mode,
                              logic [psms_pkg::SIZE_W-1:0] size);
        logic [psms_pkg::CFG_W-psms_pkg::MODE_W-1:0] pad;
        settle_pipeline();
        // junk above the mode field must be ignored
        pad = (psms_pkg::CFG_W - psms_pkg::MODE_W)'(
                  $urandom_range(0, (1 << (psms_pkg::CFG_W - psms_pkg::MODE_W)) - 1));
        i_cfg_we    <= 1'b1;
        i_cfg_index <= psms_pkg::CFG_MODE;
        i_cfg_data  <= {pad, mode};
        @(posedge i_clk);
        shadow_mode = mode;
        i_cfg_index <= psms_pkg::CFG_SIZE;
        i_cfg_data  <= size;
        @(posedge i_clk);
        shadow_size = size;
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    // random element, mostly inside the stored shape; never reads an unwritten entry
    task automatic draw_access(output logic op, output logic [psms_pkg::IDX_W-1:0] row,
                               output logic [psms_pkg::IDX_W-1:0] col,
                               output logic signed [psms_pkg::DATA_W-1:0] wv);
        int n;
        int r;
        int c;
        t_elem_loc loc;
        n = active_order();
        if (n > 0 && shadow_mode <= psms_pkg::MODE_TRI && $urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, n - 1);
            case (shadow_mode)
                psms_pkg::MODE_DIAG:  c = r;
                psms_pkg::MODE_LOWER: c = $urandom_range(0, r);
                psms_pkg::MODE_UPPER: c = $urandom_range(r, n - 1);
                psms_pkg::MODE_TRI: begin
                    c = r + int'($urandom_range(0, 2)) - 1;
                    if (c < 0 || c >= n)
                        c = r;
                end
                default:    c = $urandom_range(0, n - 1);
            endcase
        end else begin
            r = $urandom_range(0, (1 << psms_pkg::IDX_W) - 1);
            c = $urandom_range(0, (1 << psms_pkg::IDX_W) - 1);
        end
        case ($urandom_range(0, 7))
            0:       wv = 32'sh7fff_ffff;
            1:       wv = 32'sh8000_0000;
            2:       wv = '0;
            3:       wv = -32'sd1;
            default: wv = $urandom;
        endcase
        op  = $urandom_range(0, 1) ? psms_pkg::OP_READ : psms_pkg::OP_WRITE;
        loc = locate_element(r, c);
        if (op == psms_pkg::OP_READ && loc.in_range && loc.stored && !shadow_written[loc.addr])
            op = psms_pkg::OP_WRITE;
        row = r[psms_pkg::IDX_W-1:0];
        col = c[psms_pkg::IDX_W-1:0];
    endtask

    task automatic send_random(int count);
        logic                               op;
        logic [psms_pkg::IDX_W-1:0]         row;
        logic [psms_pkg::IDX_W-1:0]         col;
        logic signed [psms_pkg::DATA_W-1:0] wv;
        repeat (count) begin
            draw_access(op, row, col, wv);
            send_access(op, row, col, wv);
        end
    endtask

    // receiver: a fresh hold-off is drawn after every result transfer
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker: outputs are stable at the falling edge, the transfer follows at the rise
    always @(negedge i_clk) begin : result_check
        t_elem_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            rx_hold_left = $urandom_range(0, rx_max_hold);
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t: result with none expected: value %0d status %0d",
                             $time, o_read_value, o_status);
            end else begin
                want = expected_results.pop_front();
                if (o_read_value !== want.value) begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: read_value mismatch: expected %0d actual %0d",
                                 $time, want.value, o_read_value);
                end
                if (o_status !== want.status) begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, o_status);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // reset state: diagonal, order 16
    task automatic test_default_shape();
        send_access(psms_pkg::OP_WRITE, 4'd15, 4'd15, 32'sh7fff_ffff);
        send_access(psms_pkg::OP_READ,  4'd15, 4'd15, $urandom);
        // off-diagonal write refused, off-diagonal read gives zero
        send_access(psms_pkg::OP_WRITE, 4'd0,  4'd15, 32'sh8000_0000);
        send_access(psms_pkg::OP_READ,  4'd0,  4'd15, $urandom);
    endtask

    // stored corner, its read-back (mirror for symmetric), then a structural zero (a stored diagonal for symmetric)
    task automatic run_shape(logic [psms_pkg::MODE_W-1:0] mode,
                             logic signed [psms_pkg::DATA_W-1:0] wv,
                             logic [psms_pkg::IDX_W-1:0] sr, logic [psms_pkg::IDX_W-1:0] sc,
                             logic [psms_pkg::IDX_W-1:0] mr, logic [psms_pkg::IDX_W-1:0] mc,
                             logic [psms_pkg::IDX_W-1:0] zr, logic [psms_pkg::IDX_W-1:0] zc);
        set_config(mode, 5'd16);
        send_access(psms_pkg::OP_WRITE, sr, sc, wv);
        send_access(psms_pkg::OP_READ,  mr, mc, $urandom);
        send_access(psms_pkg::OP_WRITE, zr, zc, ~wv);
        send_access(psms_pkg::OP_READ,  zr, zc, $urandom);
    endtask

    task automatic test_each_shape();
        run_shape(psms_pkg::MODE_LOWER, 32'sh8000_0000,
                  4'd15, 4'd0,  4'd15, 4'd0,  4'd0,  4'd15);
        run_shape(psms_pkg::MODE_UPPER, 32'sh7fff_ffff,
                  4'd0,  4'd15, 4'd0,  4'd15, 4'd15, 4'd0);
        // symmetric: write above the diagonal, read the mirror below it
        run_shape(psms_pkg::MODE_SYMM,  -32'sd1,
                  4'd0,  4'd15, 4'd15, 4'd0,  4'd15, 4'd15);
        // tridiagonal: super-diagonal corner, far corner is a structural zero
        run_shape(psms_pkg::MODE_TRI,   32'sh5a5a_a5a5,
                  4'd14, 4'd15, 4'd14, 4'd15, 4'd15, 4'd0);
    endtask

    // small orders, order zero, oversize order, an unused mode code
    task automatic test_order_limits();
        set_config(psms_pkg::MODE_LOWER, 5'd5);
        send_access(psms_pkg::OP_WRITE, 4'd5, 4'd0, 32'sd77);   // row past the order
        send_access(psms_pkg::OP_READ,  4'd0, 4'd5, $urandom);  // column past the order
        send_access(psms_pkg::OP_WRITE, 4'd4, 4'd2, 32'sd123);
        set_config(psms_pkg::MODE_LOWER, 5'd0);
        send_access(psms_pkg::OP_READ,  4'd0, 4'd0, $urandom);  // order zero: nothing in range
        set_config(psms_pkg::MODE_DIAG, 5'd31);
        send_access(psms_pkg::OP_READ,  4'd15, 4'd15, $urandom); // oversize order acts as the cap
        set_config(MODE_RSVD_7, 5'd16);
        send_access(psms_pkg::OP_WRITE, 4'd2, 4'd2, 32'sd9);
        send_access(psms_pkg::OP_READ,  4'd2, 4'd2, $urandom);
    endtask

    // sender holds off until every result is back, then carries on
    task automatic test_pause_and_resume();
        set_config(psms_pkg::MODE_SYMM, 5'd12);
        tx_max_gap  = 0;
        rx_max_hold = MAX_WAIT;
        send_random(30);
        settle_pipeline();
        tx_max_gap = MAX_WAIT;
        send_random(30);
    endtask

    // many register settings, each with a burst of random accesses
    task automatic test_random_traffic();
        int                          phase;
        logic [psms_pkg::MODE_W-1:0] mode;
        logic [psms_pkg::SIZE_W-1:0] size;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // every mode code early on, then mostly real shapes
            if (phase < 8)
                mode = phase[psms_pkg::MODE_W-1:0];
            else if ($urandom_range(0, 9) == 0)
                mode = psms_pkg::MODE_W'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
            else
                mode = psms_pkg::MODE_W'($urandom_range(psms_pkg::MODE_DIAG, psms_pkg::MODE_TRI));
            case (phase % 5)
                0: size = 5'd16;
                1: size = 5'd1;
                2: size = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
                default: size = psms_pkg::SIZE_W'($urandom_range(2, ORDER_CAP));
            endcase
            set_config(mode, size);
            // stretches with no idling on one side or the other
            tx_max_gap  = (phase % 3 == 1) ? 0 : MAX_WAIT;
            rx_max_hold = (phase % 3 == 2) ? 0 : MAX_WAIT;
            send_random(PHASE_ITEMS);
        end
        tx_max_gap  = MAX_WAIT;
        rx_max_hold = MAX_WAIT;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_shape();
        test_each_shape();
        test_order_limits();
        test_pause_and_resume();
        test_random_traffic();

        settle_pipeline();
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end

        $display("run covered %0d element transfers (%0d writes, %0d reads), %0d results checked",
                 write_count + read_count, write_count, read_count, result_count);
        $display("all five shapes plus unused mode codes, orders 0 to 31, %0d register settings",
                 settings_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
